[rtl/drrip_pkg.sv]
// ----------------------------------------------------------------------------
// drrip_pkg
// Types and constants shared by the DRRIP replacement policy block.
// ----------------------------------------------------------------------------
package drrip_pkg;

  localparam int VALUE_BITS    = 2;
  localparam int SELECTOR_BITS = 10;
  localparam int CFG_DATA_BITS = 10;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [VALUE_BITS-1:0]    VAL_MAX = '1;
  localparam logic [SELECTOR_BITS-1:0] SEL_MAX = '1;
  localparam logic [SELECTOR_BITS-1:0] SEL_RESET = SEL_MAX >> 1;

  localparam logic [5:0] SRRIP_OFFSET_RESET = 6'd0;
  localparam logic [5:0] BRRIP_OFFSET_RESET = 6'd32;
  localparam logic [SELECTOR_BITS-1:0] THRESHOLD_RESET = 10'd511;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SRRIP_OFFSET = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BRRIP_OFFSET = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD    = 2'd2;

  // request modes
  localparam logic [1:0] MODE_VICTIM = 2'd0;
  localparam logic [1:0] MODE_HIT    = 2'd1;
  localparam logic [1:0] MODE_FILL   = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [10:0] set_index;
    logic [3:0]  way;
    logic [4:0]  chance;
  } in_word_t;

  typedef struct packed {
    logic [3:0]               victim_way;
    logic [VALUE_BITS-1:0]    written_value;
    logic                     used_srrip;
    logic [SELECTOR_BITS-1:0] selector;
  } out_word_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [1:0]  mode;
    logic [10:0] set_index;
    logic [3:0]  way;
    logic [4:0]  chance;
    logic        srrip_leader;
    logic        brrip_leader;
  } work_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } back_state_t;

endpackage

[rtl/drrip_queue.sv]
// ----------------------------------------------------------------------------
// drrip_queue
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module drrip_queue
  import drrip_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_word,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output work_t head_word
);

  work_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_word  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/drrip_front.sv]
// ----------------------------------------------------------------------------
// drrip_front
// Accepts requests, reduces set and way into range and marks leader sets.
// Holds the configuration registers.
// ----------------------------------------------------------------------------
module drrip_front
  import drrip_pkg::*;
#(
  parameter int SETS = 2048,
  parameter int WAYS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_word_t                  in_word,
  input  logic                      queue_full,
  input  logic                      clearing,
  output logic                      push,
  output work_t                     push_word,
  output logic [SELECTOR_BITS-1:0]  threshold
);

  logic [5:0]  srrip_offset;
  logic [5:0]  brrip_offset;
  logic [10:0] set_mod;
  logic [3:0]  way_mod;
  logic        is_srrip;

  always_ff @(posedge clk) begin
    if (rst) begin
      srrip_offset <= SRRIP_OFFSET_RESET;
      brrip_offset <= BRRIP_OFFSET_RESET;
      threshold    <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SRRIP_OFFSET: srrip_offset <= cfg_data[5:0];
        CFG_BRRIP_OFFSET: brrip_offset <= cfg_data[5:0];
        CFG_THRESHOLD:    threshold    <= cfg_data[SELECTOR_BITS-1:0];
        default:          ;
      endcase
    end
  end

  // set modulo SETS: quotient is below 32 since SETS is at least 64
  always_comb begin
    logic [31:0] r;
    r = {21'd0, in_word.set_index};
    for (int k = 4; k >= 0; k--) begin
      if (r >= (32'(SETS) << k)) begin
        r = r - (32'(SETS) << k);
      end
    end
    set_mod = r[10:0];
  end

  // way modulo WAYS: quotient is below 8 since WAYS is at least 2
  always_comb begin
    logic [31:0] r;
    r = {28'd0, in_word.way};
    for (int k = 2; k >= 0; k--) begin
      if (r >= (32'(WAYS) << k)) begin
        r = r - (32'(WAYS) << k);
      end
    end
    way_mod = r[3:0];
  end

  assign is_srrip = (set_mod[5:0] == srrip_offset);

  assign in_stall = queue_full | clearing;
  assign push     = in_valid & ~in_stall;

  always_comb begin
    push_word.mode         = in_word.mode;
    push_word.set_index    = set_mod;
    push_word.way          = way_mod;
    push_word.chance       = in_word.chance;
    push_word.srrip_leader = is_srrip;
    push_word.brrip_leader = ~is_srrip & (set_mod[5:0] == brrip_offset);
  end

endmodule

[rtl/drrip_back.sv]
// ----------------------------------------------------------------------------
// drrip_back
// Owns the re-reference value memory and the policy selector. Reads a set,
// applies the request, writes the set back and registers the result.
// ----------------------------------------------------------------------------
module drrip_back
  import drrip_pkg::*;
#(
  parameter int SETS = 2048,
  parameter int WAYS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     head_valid,
  input  work_t                    head_word,
  output logic                     pop,
  output logic                     clearing,
  input  logic [SELECTOR_BITS-1:0] threshold,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_word_t                out_word
);

  localparam int SET_BITS  = $clog2(SETS);
  localparam int WAY_BITS  = $clog2(WAYS);
  localparam int WORD_BITS = WAYS * VALUE_BITS;
  localparam int LEVELS    = 1 << VALUE_BITS;

  logic [WORD_BITS-1:0] mem [SETS];
  logic [WORD_BITS-1:0] rdata;

  back_state_t              state;
  back_state_t              state_next;
  logic [SET_BITS-1:0]      clear_addr;
  logic [SET_BITS-1:0]      clear_addr_next;
  logic [SELECTOR_BITS-1:0] selector;
  logic [SELECTOR_BITS-1:0] selector_next;
  work_t                    cur;

  logic                 mem_we;
  logic [SET_BITS-1:0]  mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic                 load_out;
  logic                 out_take;
  out_word_t            result;

  logic [LEVELS-1:0]     present;
  logic [VALUE_BITS-1:0] top;
  logic [VALUE_BITS-1:0] age;
  logic [WAY_BITS-1:0]   victim;
  logic [WORD_BITS-1:0]  aged_word;
  logic [WORD_BITS-1:0]  upd_word;
  logic [VALUE_BITS-1:0] insert_value;
  logic                  srrip_insert;

  assign out_take = out_valid & ~out_stall;
  assign clearing = (state == BK_CLEAR);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[SET_BITS'(head_word.set_index)];
    end
  end

  // age the set to bring its top value to the maximum; pick lowest way at top
  always_comb begin
    present = '0;
    for (int i = 0; i < WAYS; i++) begin
      for (int l = 0; l < LEVELS; l++) begin
        if (rdata[i*VALUE_BITS +: VALUE_BITS] == VALUE_BITS'(l)) begin
          present[l] = 1'b1;
        end
      end
    end
    top = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (present[l]) begin
        top = VALUE_BITS'(l);
      end
    end
    age = VAL_MAX - top;
    victim = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (rdata[i*VALUE_BITS +: VALUE_BITS] == top) begin
        victim = WAY_BITS'(i);
      end
    end
    for (int i = 0; i < WAYS; i++) begin
      aged_word[i*VALUE_BITS +: VALUE_BITS] = rdata[i*VALUE_BITS +: VALUE_BITS] + age;
    end
  end

  assign srrip_insert = cur.srrip_leader | (~cur.brrip_leader & (selector > threshold));

  always_comb begin
    if (cur.mode == MODE_FILL) begin
      if (srrip_insert) begin
        insert_value = VAL_MAX - VALUE_BITS'(1);
      end else if (cur.chance == 5'd0) begin
        insert_value = '0;
      end else begin
        insert_value = VAL_MAX;
      end
    end else begin
      insert_value = '0;
    end
    upd_word = rdata;
    for (int i = 0; i < WAYS; i++) begin
      if (int'(cur.way) == i) begin
        upd_word[i*VALUE_BITS +: VALUE_BITS] = insert_value;
      end
    end
  end

  always_comb begin
    state_next      = state;
    clear_addr_next = clear_addr;
    selector_next   = selector;
    mem_we          = 1'b0;
    mem_waddr       = SET_BITS'(cur.set_index);
    mem_wdata       = upd_word;
    mem_re          = 1'b0;
    pop             = 1'b0;
    load_out        = 1'b0;
    result          = '0;
    result.selector = selector;

    case (state)
      BK_CLEAR: begin
        mem_we          = 1'b1;
        mem_waddr       = clear_addr;
        mem_wdata       = '1;
        clear_addr_next = clear_addr + SET_BITS'(1);
        if (clear_addr == SET_BITS'(SETS - 1)) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (head_valid) begin
          pop        = 1'b1;
          mem_re     = 1'b1;
          state_next = BK_EXEC;
        end
      end
      BK_EXEC: begin
        // hold until the output register is free
        if (!out_valid || out_take) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
          case (cur.mode)
            MODE_VICTIM: begin
              mem_we            = 1'b1;
              mem_wdata         = aged_word;
              result.victim_way = 4'(victim);
            end
            MODE_HIT: begin
              mem_we = 1'b1;
              if (cur.srrip_leader) begin
                if (selector != SEL_MAX) begin
                  selector_next = selector + SELECTOR_BITS'(1);
                end
              end else if (cur.brrip_leader) begin
                if (selector != '0) begin
                  selector_next = selector - SELECTOR_BITS'(1);
                end
              end
              result.selector = selector_next;
            end
            MODE_FILL: begin
              mem_we               = 1'b1;
              result.written_value = insert_value;
              result.used_srrip    = srrip_insert;
            end
            default: ;
          endcase
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_CLEAR;
      clear_addr <= '0;
      selector   <= SEL_RESET;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      clear_addr <= clear_addr_next;
      selector   <= selector_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_word;
    end
    if (load_out) begin
      out_word <= result;
    end
  end

endmodule

[rtl/drrip_replacement_policy_top.sv]
// ----------------------------------------------------------------------------
// drrip_replacement_policy_top
// DRRIP cache replacement policy: victim selection, hit and fill updates.
// ----------------------------------------------------------------------------
// Each request produces one result word. In the back end the set's value
// word is first read from the memory, then updated and written back while
// the result is registered; the back end takes no new request until it is
// through with the last one. out_valid rises when the result register is
// loaded, which waits while an earlier result is held by out_stall. After
// reset the value memory is swept to all ways at the maximum value, one set
// per cycle; in_stall stays high during the sweep. Configuration writes are
// taken at any time but must be made while idle.
// ----------------------------------------------------------------------------
module drrip_replacement_policy_top
  import drrip_pkg::*;
#(
  parameter int SETS = 2048,
  parameter int WAYS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_word_t                  in_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_word_t                 out_word
);

  logic                     push;
  work_t                    push_word;
  logic                     queue_full;
  logic                     head_valid;
  work_t                    head_word;
  logic                     pop;
  logic                     clearing;
  logic [SELECTOR_BITS-1:0] threshold;

  drrip_front #(
    .SETS (SETS),
    .WAYS (WAYS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .queue_full (queue_full),
    .clearing   (clearing),
    .push       (push),
    .push_word  (push_word),
    .threshold  (threshold)
  );

  drrip_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_word  (push_word),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_word  (head_word)
  );

  drrip_back #(
    .SETS (SETS),
    .WAYS (WAYS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_word  (head_word),
    .pop        (pop),
    .clearing   (clearing),
    .threshold  (threshold),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

endmodule
